### hdl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console character writer: shared definitions
// Request codes, character codes, field widths and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Default screen geometry.
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Fixed payload widths.
  localparam int REQ_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int IDX_W   = 11;
  localparam int CCOL_W  = 7;
  localparam int CROW_W  = 5;
  localparam int CELL_W  = 16;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FILL = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

  // Character codes with special meaning.
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

  // Attribute register reset value.
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the request fields
    logic put_char;   // write a printable character and advance
    logic newline;    // move to the start of the next line
    logic backspace;  // step back and blank the cell
    logic rd_cell;    // read one cell for the result
    logic home;       // cursor to the top left corner
    logic ptr_clr;    // restart the sweep pointer
    logic copy_rd;    // scroll: fetch the cell one row below
    logic blank_wr;   // scroll: blank one cell of the bottom text row
    logic fill_wr;    // fill: blank one cell with the fill attribute
  } tcw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             is_newline;
    logic             is_backspace;
    logic             wrap;
    logic             last_line;
    logic             copy_last;
    logic             blank_last;
    logic             fill_last;
  } tcw_sts_t;

endpackage

### hdl/tcw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console character writer: datapath
// Holds the screen memory, the cursor, the captured request and the sweep
// pointer used by scroll and fill. Acts on commands from the controller.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcw_pkg::tcw_cmd_t           cmd_i,
  output tcw_pkg::tcw_sts_t           sts_o,
  input  logic [tcw_pkg::REQ_W-1:0]   req_type_i,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code_i,
  input  logic [tcw_pkg::ATTR_W-1:0]  fill_attr_i,
  input  logic [tcw_pkg::IDX_W-1:0]   cell_index_i,
  input  logic [tcw_pkg::ATTR_W-1:0]  text_attr_i,
  output logic [tcw_pkg::CCOL_W-1:0]  cursor_col_o,
  output logic [tcw_pkg::CROW_W-1:0]  cursor_row_o,
  output logic [tcw_pkg::CELL_W-1:0]  read_cell_o
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int TOP    = (ROWS - 2) * COLUMNS;
  localparam int CMP_W  = (ADDR_W > tcw_pkg::IDX_W) ? ADDR_W : tcw_pkg::IDX_W;

  // Captured request fields.
  logic [tcw_pkg::REQ_W-1:0]  req_q;
  logic [tcw_pkg::CHAR_W-1:0] char_q;
  logic [tcw_pkg::ATTR_W-1:0] fattr_q;
  logic [tcw_pkg::IDX_W-1:0]  idx_q;

  // Cursor, sweep pointer and pending copy.
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [ADDR_W-1:0] cpy_addr_q;
  logic              cpy_v_q;
  logic              rd_hit_q;

  // Screen memory.
  logic [tcw_pkg::CELL_W-1:0] mem_q [CELLS];
  logic [tcw_pkg::CELL_W-1:0] rdata_q;

  logic                       we;
  logic [ADDR_W-1:0]          waddr;
  logic [tcw_pkg::CELL_W-1:0] wdata;
  logic [ADDR_W-1:0]          raddr;

  logic [COL_W-1:0]  bs_col;
  logic [ROW_W-1:0]  bs_row;
  logic [ROW_W-1:0]  nl_row;
  logic [COL_W-1:0]  a_col;
  logic [ROW_W-1:0]  a_row;
  logic [ADDR_W-1:0] cur_addr;
  logic              wrap;
  logic              last_line;
  logic [CMP_W-1:0]  idx_w;
  logic              idx_hit;
  logic [COL_W+tcw_pkg::CCOL_W-1:0] col_ext;
  logic [ROW_W+tcw_pkg::CROW_W-1:0] row_ext;

  // Capture the request at acceptance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_type_i;
      char_q  <= char_code_i;
      fattr_q <= fill_attr_i;
      idx_q   <= cell_index_i;
    end
  end

  // Cursor position tests and the position one cell back.
  assign wrap      = (col_q == COL_W'(COLUMNS - 1));
  assign last_line = (row_q == ROW_W'(ROWS - 2));
  assign nl_row    = last_line ? row_q : row_q + 1'b1;

  always_comb begin
    bs_col = col_q;
    bs_row = row_q;
    if (col_q != '0) begin
      bs_col = col_q - 1'b1;
    end else if (row_q != '0) begin
      bs_row = row_q - 1'b1;
      bs_col = COL_W'(COLUMNS - 1);
    end
  end

  // Linear address of the cell being written by put or backspace.
  assign a_col    = cmd_i.backspace ? bs_col : col_q;
  assign a_row    = cmd_i.backspace ? bs_row : row_q;
  assign cur_addr = ADDR_W'(ADDR_W'(a_row) * ADDR_W'(COLUMNS)) + ADDR_W'(a_col);

  // Cursor update.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.home) begin
      col_d = '0;
      row_d = '0;
    end else if (cmd_i.newline) begin
      col_d = '0;
      row_d = nl_row;
    end else if (cmd_i.put_char) begin
      if (wrap) begin
        col_d = '0;
        row_d = nl_row;
      end else begin
        col_d = col_q + 1'b1;
      end
    end else if (cmd_i.backspace) begin
      col_d = bs_col;
      row_d = bs_row;
    end
  end

  // Sweep pointer for scroll and fill.
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_clr) begin
      ptr_d = '0;
    end else if (cmd_i.copy_rd || cmd_i.blank_wr || cmd_i.fill_wr) begin
      ptr_d = ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      ptr_q    <= '0;
      cpy_v_q  <= 1'b0;
      rd_hit_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      ptr_q   <= ptr_d;
      cpy_v_q <= cmd_i.copy_rd;
      if (cmd_i.load) begin
        rd_hit_q <= 1'b0;
      end else if (cmd_i.rd_cell) begin
        rd_hit_q <= idx_hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.copy_rd) begin
      cpy_addr_q <= ptr_q;
    end
  end

  // Read index range check.
  assign idx_w   = CMP_W'(idx_q);
  assign idx_hit = (idx_w < CMP_W'(CELLS));

  // Memory port selection: a pending scroll copy owns the write port.
  always_comb begin
    we    = 1'b0;
    waddr = ptr_q;
    wdata = {text_attr_i, tcw_pkg::CH_SPACE};
    if (cpy_v_q) begin
      we    = 1'b1;
      waddr = cpy_addr_q;
      wdata = rdata_q;
    end else if (cmd_i.put_char) begin
      we    = 1'b1;
      waddr = cur_addr;
      wdata = {text_attr_i, char_q};
    end else if (cmd_i.backspace) begin
      we    = 1'b1;
      waddr = cur_addr;
    end else if (cmd_i.blank_wr) begin
      we    = 1'b1;
    end else if (cmd_i.fill_wr) begin
      we    = 1'b1;
      wdata = {fattr_q, tcw_pkg::CH_SPACE};
    end
  end

  assign raddr = cmd_i.copy_rd ? ptr_q + ADDR_W'(COLUMNS) :
                 (idx_hit ? ADDR_W'(idx_w) : '0);

  // Single write port, single registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  // Status towards the controller.
  assign sts_o.req          = req_q;
  assign sts_o.is_newline   = (char_q == tcw_pkg::CH_NEWLINE);
  assign sts_o.is_backspace = (char_q == tcw_pkg::CH_BACKSPACE);
  assign sts_o.wrap         = wrap;
  assign sts_o.last_line    = last_line;
  assign sts_o.copy_last    = (ptr_q == ADDR_W'(TOP - 1));
  assign sts_o.blank_last   = (ptr_q == ADDR_W'(TOP + COLUMNS - 1));
  assign sts_o.fill_last    = (ptr_q == ADDR_W'(CELLS - 1));

  // Result fields.
  assign col_ext      = (COL_W + tcw_pkg::CCOL_W)'(col_q);
  assign row_ext      = (ROW_W + tcw_pkg::CROW_W)'(row_q);
  assign cursor_col_o = col_ext[tcw_pkg::CCOL_W-1:0];
  assign cursor_row_o = row_ext[tcw_pkg::CROW_W-1:0];
  assign read_cell_o  = rd_hit_q ? rdata_q : '0;

  // The cursor never enters the status row.
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= ROW_W'(ROWS - 2))
    else $error("cursor row reached the reserved last row");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= COL_W'(COLUMNS - 1))
    else $error("cursor column beyond the screen width");

  // A scroll copy write never competes with another write.
  a_wr_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cpy_v_q |-> !(cmd_i.put_char || cmd_i.backspace || cmd_i.blank_wr || cmd_i.fill_wr))
    else $error("write port conflict during scroll copy");

endmodule

### hdl/tcw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console character writer: controller
// Sequences each request: capture, execute, and the scroll and fill sweeps.
// Raises the result strobe once the work of a request is complete.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  tcw_pkg::tcw_sts_t sts_i,
  output tcw_pkg::tcw_cmd_t cmd_o,
  output logic              busy_o,
  output logic              done_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL_COPY,
    ST_SCROLL_TAIL,
    ST_SCROLL_BLANK,
    ST_FILL
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts_i.req)
          tcw_pkg::REQ_PUT: begin
            if (sts_i.is_newline) begin
              cmd_o.newline = 1'b1;
              if (sts_i.last_line) begin
                cmd_o.ptr_clr = 1'b1;
                state_d       = ST_SCROLL_COPY;
              end else begin
                done_d  = 1'b1;
                state_d = ST_IDLE;
              end
            end else if (sts_i.is_backspace) begin
              cmd_o.backspace = 1'b1;
              done_d          = 1'b1;
              state_d         = ST_IDLE;
            end else begin
              cmd_o.put_char = 1'b1;
              if (sts_i.wrap && sts_i.last_line) begin
                cmd_o.ptr_clr = 1'b1;
                state_d       = ST_SCROLL_COPY;
              end else begin
                done_d  = 1'b1;
                state_d = ST_IDLE;
              end
            end
          end
          tcw_pkg::REQ_FILL: begin
            cmd_o.home    = 1'b1;
            cmd_o.ptr_clr = 1'b1;
            state_d       = ST_FILL;
          end
          tcw_pkg::REQ_READ: begin
            cmd_o.rd_cell = 1'b1;
            done_d        = 1'b1;
            state_d       = ST_IDLE;
          end
          default: begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_SCROLL_COPY: begin
        cmd_o.copy_rd = 1'b1;
        if (sts_i.copy_last) begin
          state_d = ST_SCROLL_TAIL;
        end
      end
      ST_SCROLL_TAIL: begin
        // The last copied cell is written back in this cycle.
        state_d = ST_SCROLL_BLANK;
      end
      ST_SCROLL_BLANK: begin
        cmd_o.blank_wr = 1'b1;
        if (sts_i.blank_last) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (sts_i.fill_last) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

  // The strobe appears only once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == ST_IDLE)
    else $error("result strobe while a request is still in progress");

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) != ST_IDLE)
    else $error("result strobe without a request being executed");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && start_i) |=> state_q == ST_EXEC)
    else $error("accepted request did not enter execution");

  a_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCROLL_TAIL |-> $past(state_q) == ST_SCROLL_COPY)
    else $error("scroll tail entered without a copy sweep");

endmodule

### hdl/text_console_char_writer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console character writer
// Console engine owning a screen of character cells and a cursor, with put,
// fill and read requests and an APB attribute register.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low. Its
//   transaction result (cursor position and, for a read, the cell) is shown
//   for exactly one cycle, marked by done_o; the receiver cannot stall it.
//   A plain put, backspace, newline without scroll, read or unknown request
//   is executed in the execution state; done_o is registered from that state,
//   and a new request may be accepted in the cycle in which done_o is high.
//   A put or newline that scrolls and a fill both sweep the screen one
//   cell per cycle through the single write port of the screen memory;
//   busy stays high meanwhile.
//   The text attribute register lies at byte address 0 and is written
//   through the APB port; the user must write it only while no request is
//   in progress, since the block itself does not enforce this.
//   Reset homes the cursor and sets the attribute to 15. Screen contents
//   are undefined until written; software fills the screen first.
// ----------------------------------------------------------------------------
module text_console_char_writer_unit #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Request channel
  input  logic                        start,
  output logic                        busy,
  input  logic [tcw_pkg::REQ_W-1:0]   req_type_i,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code_i,
  input  logic [tcw_pkg::ATTR_W-1:0]  fill_attr_i,
  input  logic [tcw_pkg::IDX_W-1:0]   cell_index_i,
  // Result channel
  output logic                        done_o,
  output logic [tcw_pkg::CCOL_W-1:0]  cursor_col_o,
  output logic [tcw_pkg::CROW_W-1:0]  cursor_row_o,
  output logic [tcw_pkg::CELL_W-1:0]  read_cell_o,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcw_pkg::APB_AW-1:0]  paddr,
  input  logic [tcw_pkg::APB_DW-1:0]  pwdata,
  output logic [tcw_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  tcw_pkg::tcw_cmd_t          cmd;
  tcw_pkg::tcw_sts_t          sts;
  logic [tcw_pkg::ATTR_W-1:0] text_attr_q;
  logic                       attr_sel;

  // Register decode: only the text attribute register at word 0.
  assign attr_sel = (paddr[tcw_pkg::APB_AW-1] == 1'b0);
  assign pready   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q <= tcw_pkg::ATTR_RESET;
    end else if (psel && penable && pwrite && attr_sel) begin
      text_attr_q <= pwdata[tcw_pkg::ATTR_W-1:0];
    end
  end

  assign prdata = attr_sel ? tcw_pkg::APB_DW'(text_attr_q) : '0;

  // Request sequencer.
  tcw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // Screen memory, cursor and sweep logic.
  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (req_type_i),
    .char_code_i  (char_code_i),
    .fill_attr_i  (fill_attr_i),
    .cell_index_i (cell_index_i),
    .text_attr_i  (text_attr_q),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .read_cell_o  (read_cell_o)
  );

endmodule

### tb/text_console_char_writer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console character writer: self-checking testbench
// Drives put, fill, read and unknown requests into the console engine in
// random bursts. A shadow copy of the screen, the cursor and the attribute
// register predicts every result, and each result is checked field by field.
// The attribute register is rewritten between phases and read back each time.
// ----------------------------------------------------------------------------
module text_console_char_writer_unit_test;

  // Screen geometry and run sizing.
  localparam int TEXT_COLS      = 80;
  localparam int TEXT_ROWS      = 25;
  localparam int CELLS          = TEXT_COLS * TEXT_ROWS;
  localparam int PHASES         = 5;
  localparam int ITEMS_PER_PHASE = 400;
  localparam int TAIL_CYCLES    = 16;
  // Worst case: every request sweeps the whole screen after the longest gap.
  localparam longint CYCLE_LIMIT = 64'd3 * 2100 * (CELLS + 32);

  // Request code that the block ignores, and the register address.
  localparam logic [tcw_pkg::REQ_W-1:0]  REQ_UNKNOWN    = 2'd3;
  localparam logic [tcw_pkg::APB_AW-1:0] ADDR_TEXT_ATTR = 3'd0;

  typedef struct packed {
    logic [tcw_pkg::REQ_W-1:0]  req;
    logic [tcw_pkg::CHAR_W-1:0] ch;
    logic [tcw_pkg::ATTR_W-1:0] fattr;
    logic [tcw_pkg::IDX_W-1:0]  idx;
  } console_req_t;

  typedef struct packed {
    logic [tcw_pkg::CCOL_W-1:0] col;
    logic [tcw_pkg::CROW_W-1:0] row;
    logic [tcw_pkg::CELL_W-1:0] cell_data;
  } console_sts_t;

  typedef struct packed {
    console_req_t rq;
    console_sts_t st;
  } console_op_t;

  // Block ports.
  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         start        = 1'b0;
  logic                         busy;
  logic [tcw_pkg::REQ_W-1:0]    req_type     = '0;
  logic [tcw_pkg::CHAR_W-1:0]   char_code    = '0;
  logic [tcw_pkg::ATTR_W-1:0]   fill_attr    = '0;
  logic [tcw_pkg::IDX_W-1:0]    cell_index   = '0;
  logic                         done_o;
  logic [tcw_pkg::CCOL_W-1:0]   cursor_col;
  logic [tcw_pkg::CROW_W-1:0]   cursor_row;
  logic [tcw_pkg::CELL_W-1:0]   read_cell;
  logic                         psel         = 1'b0;
  logic                         penable      = 1'b0;
  logic                         pwrite       = 1'b0;
  logic [tcw_pkg::APB_AW-1:0]   paddr        = '0;
  logic [tcw_pkg::APB_DW-1:0]   pwdata       = '0;
  logic [tcw_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  // Shadow console state used for prediction.
  logic [tcw_pkg::CELL_W-1:0] shadow_cells [CELLS];
  bit                         shadow_written [CELLS];
  int                         shadow_col;
  int                         shadow_row;
  logic [tcw_pkg::ATTR_W-1:0] shadow_attr;

  // Requests waiting to be offered, and results owed by the block.
  console_op_t  pending_ops[$];
  console_sts_t owed_status[$];
  console_op_t  on_offer;

  int     gap_left;
  int     burst_left;
  int     mismatch_count;
  int     accepted_count;
  int     queued_count;
  int     results_seen;
  int     scroll_count;
  int     wrap_count;
  int     attr_settings;
  int     type_count [4];
  longint cycle_count;

  text_console_char_writer_unit #(
    .COLUMNS(TEXT_COLS),
    .ROWS   (TEXT_ROWS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type),
    .char_code_i (char_code),
    .fill_attr_i (fill_attr),
    .cell_index_i(cell_index),
    .done_o      (done_o),
    .cursor_col_o(cursor_col),
    .cursor_row_o(cursor_row),
    .read_cell_o (read_cell),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 125 MHz clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Prints one line per mismatch and counts them all.
  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Writes one cell of the shadow screen.
  task automatic shadow_store(input int pos, input logic [tcw_pkg::CHAR_W-1:0] ch,
                              input logic [tcw_pkg::ATTR_W-1:0] attr);
    shadow_cells[pos]   = {attr, ch};
    shadow_written[pos] = 1'b1;
  endtask

  // Start of the next line; past the second-to-last row the text rows move
  // up by one, that row is blanked and the bottom row is left alone.
  task automatic shadow_next_line();
    int top;
    shadow_col = 0;
    shadow_row++;
    if (shadow_row >= TEXT_ROWS - 1) begin
      top = (TEXT_ROWS - 2) * TEXT_COLS;
      for (int i = 0; i < top; i++) begin
        shadow_cells[i]   = shadow_cells[i + TEXT_COLS];
        shadow_written[i] = shadow_written[i + TEXT_COLS];
      end
      for (int i = 0; i < TEXT_COLS; i++) begin
        shadow_store(top + i, tcw_pkg::CH_SPACE, shadow_attr);
      end
      shadow_row = TEXT_ROWS - 2;
      scroll_count++;
    end
  endtask

  // Applies one request to the shadow console and returns its result.
  task automatic console_predict(input console_req_t rq, output console_sts_t st);
    st = '0;
    case (rq.req)
      tcw_pkg::REQ_PUT: begin
        if (rq.ch == tcw_pkg::CH_NEWLINE) begin
          shadow_next_line();
        end else if (rq.ch == tcw_pkg::CH_BACKSPACE) begin
          // Backspace crosses to the end of the previous row, never above the top.
          if (shadow_col > 0) begin
            shadow_col--;
          end else if (shadow_row > 0) begin
            shadow_row--;
            shadow_col = TEXT_COLS - 1;
          end
          shadow_store(shadow_row * TEXT_COLS + shadow_col, tcw_pkg::CH_SPACE, shadow_attr);
        end else begin
          shadow_store(shadow_row * TEXT_COLS + shadow_col, rq.ch, shadow_attr);
          shadow_col++;
          if (shadow_col >= TEXT_COLS) begin
            wrap_count++;
            shadow_next_line();
          end
        end
      end
      tcw_pkg::REQ_FILL: begin
        for (int i = 0; i < CELLS; i++) shadow_store(i, tcw_pkg::CH_SPACE, rq.fattr);
        shadow_col = 0;
        shadow_row = 0;
      end
      tcw_pkg::REQ_READ: begin
        if (rq.idx < CELLS) st.cell_data = shadow_cells[rq.idx];
      end
      default: ;
    endcase
    st.col = shadow_col[tcw_pkg::CCOL_W-1:0];
    st.row = shadow_row[tcw_pkg::CROW_W-1:0];
  endtask

  // Predicts a request and queues it for the driver.
  task automatic queue_request(input logic [tcw_pkg::REQ_W-1:0] req,
                               input logic [tcw_pkg::CHAR_W-1:0] ch,
                               input logic [tcw_pkg::ATTR_W-1:0] fattr,
                               input logic [tcw_pkg::IDX_W-1:0] idx);
    console_op_t op;
    op.rq = '{req: req, ch: ch, fattr: fattr, idx: idx};
    console_predict(op.rq, op.st);
    type_count[req]++;
    queued_count++;
    pending_ops.push_back(op);
  endtask

  // One random request; reads only touch cells already written, or lie
  // beyond the screen.
  task automatic queue_random_request(input int nl_pct);
    logic [tcw_pkg::REQ_W-1:0]  req;
    logic [tcw_pkg::CHAR_W-1:0] ch;
    logic [tcw_pkg::IDX_W-1:0]  idx;
    int pick;
    int tries;
    ch   = tcw_pkg::CHAR_W'($urandom_range(0, 255));
    idx  = tcw_pkg::IDX_W'($urandom_range(0, 2047));
    pick = int'($urandom_range(0, 99));
    if (pick < 1) begin
      req = tcw_pkg::REQ_FILL;
    end else if (pick < 4) begin
      req = REQ_UNKNOWN;
    end else if (pick < 30) begin
      req  = tcw_pkg::REQ_READ;
      pick = int'($urandom_range(0, 99));
      if (pick < 10) begin
        idx = tcw_pkg::IDX_W'($urandom_range(CELLS, 2047));
      end else begin
        tries = 0;
        do begin
          if (pick < 50) begin
            idx = tcw_pkg::IDX_W'(shadow_row * TEXT_COLS +
                                  int'($urandom_range(0, TEXT_COLS - 1)));
          end else if (pick < 60) begin
            idx = tcw_pkg::IDX_W'((TEXT_ROWS - 1) * TEXT_COLS +
                                  int'($urandom_range(0, TEXT_COLS - 1)));
          end else begin
            idx = tcw_pkg::IDX_W'($urandom_range(0, CELLS - 1));
          end
          tries++;
        end while (!shadow_written[idx] && tries < 8);
        if (!shadow_written[idx]) idx = tcw_pkg::IDX_W'($urandom_range(CELLS, 2047));
      end
    end else begin
      req  = tcw_pkg::REQ_PUT;
      pick = int'($urandom_range(0, 99));
      if (pick < nl_pct) ch = tcw_pkg::CH_NEWLINE;
      else if (pick < nl_pct + 8) ch = tcw_pkg::CH_BACKSPACE;
      else if (pick >= nl_pct + 14) ch = tcw_pkg::CHAR_W'($urandom_range(8'h20, 8'h7E));
    end
    queue_request(req, ch, tcw_pkg::ATTR_W'($urandom_range(0, 255)), idx);
  endtask

  // One APB transaction to the attribute register.
  task automatic apb_transfer(input bit wr, input logic [tcw_pkg::APB_DW-1:0] wdata,
                              output logic [tcw_pkg::APB_DW-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_TEXT_ATTR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reads the attribute register back and compares it with the shadow.
  task automatic verify_text_attr();
    logic [tcw_pkg::APB_DW-1:0] rdata;
    apb_transfer(1'b0, '0, rdata);
    if (rdata[tcw_pkg::ATTR_W-1:0] !== shadow_attr)
      flag_mismatch($sformatf("text_attr read %0h, expected %0h",
                              rdata[tcw_pkg::ATTR_W-1:0], shadow_attr));
  endtask

  task automatic set_text_attr(input logic [tcw_pkg::ATTR_W-1:0] value);
    logic [tcw_pkg::APB_DW-1:0] rdata;
    apb_transfer(1'b1, tcw_pkg::APB_DW'(value), rdata);
    shadow_attr = value;
    attr_settings++;
    verify_text_attr();
  endtask

  // Waits until every queued request has been taken and its result seen.
  task automatic wait_console_idle();
    @(posedge clk_i);
    while (pending_ops.size() != 0 || start || busy || owed_status.size() != 0 ||
           results_seen != queued_count)
      @(posedge clk_i);
  endtask

  // Request driver: offers queued requests in bursts with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    bit taken;
    bit offer;
    if (!rst_ni) begin
      start      <= 1'b0;
      gap_left   = 0;
      burst_left = 0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        owed_status.push_back(on_offer.st);
        accepted_count++;
      end
      offer = start && !taken;
      if (!offer && pending_ops.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          on_offer   = pending_ops.pop_front();
          offer      = 1'b1;
          req_type   <= on_offer.rq.req;
          char_code  <= on_offer.rq.ch;
          fill_attr  <= on_offer.rq.fattr;
          cell_index <= on_offer.rq.idx;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = int'($urandom_range(1, 16));
            gap_left   = ($urandom_range(0, 9) < 4) ? 0 : int'($urandom_range(1, 6));
          end
        end
      end
      start <= offer;
    end
  end

  // Result monitor: each strobed result is checked against the oldest owed one.
  always @(posedge clk_i) begin : result_monitor
    console_sts_t due;
    if (rst_ni && done_o) begin
      if (owed_status.size() == 0) begin
        flag_mismatch("result with no request outstanding");
      end else begin
        due = owed_status.pop_front();
        results_seen++;
        if (cursor_col !== due.col)
          flag_mismatch($sformatf("result %0d: cursor_col %0d, expected %0d",
                                  results_seen, cursor_col, due.col));
        if (cursor_row !== due.row)
          flag_mismatch($sformatf("result %0d: cursor_row %0d, expected %0d",
                                  results_seen, cursor_row, due.row));
        if (read_cell !== due.cell_data)
          flag_mismatch($sformatf("result %0d: read_cell %04h, expected %04h",
                                  results_seen, read_cell, due.cell_data));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               owed_status.size());
      $display("text_console_char_writer_unit_test: FAIL");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin : stimulus
    int nl_pct;
    shadow_col  = 0;
    shadow_row  = 0;
    shadow_attr = tcw_pkg::ATTR_RESET;
    for (int i = 0; i < CELLS; i++) begin
      shadow_cells[i]   = '0;
      shadow_written[i] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    verify_text_attr();

    // Directed part at the reset attribute.
    queue_request(tcw_pkg::REQ_PUT, 8'h41, 8'h00, 11'd0);
    queue_request(tcw_pkg::REQ_READ, 8'h00, 8'h00, 11'd0);
    queue_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_BACKSPACE, 8'h00, 11'd0);
    queue_request(tcw_pkg::REQ_READ, 8'hFF, 8'hFF, 11'd0);
    // Backspace at the top left corner leaves the cursor where it is.
    queue_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_BACKSPACE, 8'h00, 11'd0);
    queue_request(REQ_UNKNOWN, 8'hFF, 8'hFF, 11'd2047);
    queue_request(tcw_pkg::REQ_FILL, 8'h00, 8'h00, 11'd0);
    queue_request(tcw_pkg::REQ_READ, 8'h00, 8'h00, 11'(CELLS - 1));
    queue_request(tcw_pkg::REQ_FILL, 8'hFF, 8'hFF, 11'd2047);
    // Reads beyond the screen return zero.
    queue_request(tcw_pkg::REQ_READ, 8'h00, 8'h00, 11'd2047);
    queue_request(tcw_pkg::REQ_READ, 8'h00, 8'h00, 11'(CELLS));
    queue_request(tcw_pkg::REQ_PUT, 8'hFF, 8'hFF, 11'd2047);
    queue_request(tcw_pkg::REQ_PUT, 8'h80, 8'h00, 11'd0);
    queue_request(tcw_pkg::REQ_PUT, 8'h00, 8'h00, 11'd0);
    queue_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_NEWLINE, 8'h00, 11'd0);
    // Backspace at column 0 crosses to the last column of the row above.
    queue_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_BACKSPACE, 8'h00, 11'd0);
    queue_request(tcw_pkg::REQ_READ, 8'h00, 8'h00, 11'(TEXT_COLS - 1));
    // A character in the last column wraps to the next row.
    queue_request(tcw_pkg::REQ_PUT, 8'h5A, 8'h00, 11'd0);
    queue_request(tcw_pkg::REQ_READ, 8'h00, 8'h00, 11'(TEXT_COLS - 1));
    queue_request(tcw_pkg::REQ_PUT, 8'h7F, 8'hFF, 11'd2047);
    queue_request(tcw_pkg::REQ_READ, 8'h00, 8'h00, 11'd1024);
    queue_request(tcw_pkg::REQ_READ, 8'h00, 8'h00, 11'd1023);
    queue_request(tcw_pkg::REQ_READ, 8'h00, 8'h00, 11'(CELLS - 1));
    wait_console_idle();

    // Random phases, each under its own attribute setting.
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) set_text_attr(8'h00);
      else if (phase == 1) set_text_attr(8'hFF);
      else set_text_attr(tcw_pkg::ATTR_W'($urandom_range(0, 255)));
      nl_pct = 10;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Vary the line length so that both wraps and newlines scroll.
        if (n % 80 == 0) nl_pct = int'($urandom_range(0, 20));
        queue_random_request(nl_pct);
      end
      wait_console_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests (%0d put, %0d fill, %0d read, %0d unknown), %0d results.",
             accepted_count, type_count[tcw_pkg::REQ_PUT], type_count[tcw_pkg::REQ_FILL],
             type_count[tcw_pkg::REQ_READ], type_count[REQ_UNKNOWN], results_seen);
    $display("Screen scrolled %0d times, %0d line wraps, %0d attribute settings, %0d mismatches.",
             scroll_count, wrap_count, attr_settings, mismatch_count);
    if (mismatch_count == 0) begin
      $display("text_console_char_writer_unit_test: PASS");
    end else begin
      $display("text_console_char_writer_unit_test: FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/tcw_pkg.sv
hdl/tcw_datapath.sv
hdl/tcw_ctrl.sv
hdl/text_console_char_writer_unit.sv
tb/text_console_char_writer_unit_test.sv
